// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue: word types, command codes and the
// control struct that the top level hands to every storage cell. No dependencies.
package spq_pkg;

  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } spq_cmd_e;

  typedef struct packed {
    spq_cmd_e           cmd;
    logic [31:0]        item_value;
    logic signed [31:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [4:0]         comparisons;
    logic [31:0]        out_value;
    logic signed [31:0] out_priority;
    logic               underflow;
    logic               overflow;
    logic [31:0]        head_value;
    logic               is_empty;
  } spq_out_t;

  typedef struct packed {
    logic [31:0]        value;
    logic signed [31:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t item;
  } spq_ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One storage cell of the sorted chain: holds one entry and drives its insert flag.
// Depends on spq_pkg for the entry and control types.
module spq_cell import spq_pkg::*; #(
  parameter bit IsHead = 1'b0
) (
  input  logic       clk_i,
  input  spq_ctl_t   ctl_i,
  input  logic       valid_i,
  input  logic       left_flag_i,
  input  spq_entry_t left_i,
  input  spq_entry_t right_i,
  output logic       flag_o,
  output spq_entry_t entry_o
);

  spq_entry_t entry_q, entry_d;

  // The flag is set when the new word belongs at this cell or in front of it.
  always_comb begin
    if (IsHead) begin
      flag_o = !valid_i || (ctl_i.item.prio > entry_q.prio);
    end else begin
      flag_o = !valid_i || !(entry_q.prio > ctl_i.item.prio);
    end
  end

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.enq) begin
      if (left_flag_i) begin
        entry_d = left_i;
      end else if (flag_o) begin
        entry_d = ctl_i.item;
      end
    end else if (ctl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: a chain of spq_cell storage cells,
// the fill count and the registered result word. Depends on spq_pkg and spq_cell.
//
//   channel   taken at edge     ports    word
//   command   start && !busy    req_i    spq_in_t: cmd, item_value, item_priority
//   result    done_o            rsp_o    spq_out_t, held for the one cycle done_o is high
//
// A command word is taken in every cycle that start is high; busy stays low. Its result word
// shows in the cycle after acceptance, for exactly one cycle, and the receiver cannot stall it.
// All cells compare against the new priority in parallel and shift by one place in
// the same cycle, so the cycle is set by one 32-bit compare plus the one-hot
// position encode.
// Reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  req_i,
  output logic     done_o,
  output spq_out_t rsp_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          done_q;
  spq_out_t      rsp_q, rsp_d;

  spq_ctl_t   ctl;
  spq_entry_t entries [DEPTH];
  logic       flags   [DEPTH];
  logic       accept, is_full, is_nonempty;
  logic [4:0] pos;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign is_full     = (count_q == CW'(DEPTH));
  assign is_nonempty = (count_q != '0);

  assign ctl.enq  = accept && (req_i.cmd == CMD_ENQ) && !is_full;
  assign ctl.deq  = accept && (req_i.cmd == CMD_DEQ) && is_nonempty;
  assign ctl.item = '{value: req_i.item_value, prio: req_i.item_priority};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       valid;
    logic       left_flag;
    spq_entry_t left_entry, right_entry;

    assign valid = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_flag  = 1'b0;
      assign left_entry = ctl.item;
    end else begin : g_body
      assign left_flag  = flags[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = ctl.item;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell #(
      .IsHead (i == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (valid),
      .left_flag_i (left_flag),
      .left_i      (left_entry),
      .right_i     (right_entry),
      .flag_o      (flags[i]),
      .entry_o     (entries[i])
    );
  end

  // The flags form a run of zeros then ones; the first one is the insert place.
  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (flags[i] && (i == 0 || !flags[(i == 0) ? 0 : i - 1])) begin
        pos = pos | 5'(i);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CW'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CW'(1);
    end

    rsp_d              = '0;
    rsp_d.is_empty     = (count_d == '0);
    rsp_d.comparisons  = ctl.enq ? (pos + 5'd1) : 5'd0;
    rsp_d.underflow    = (req_i.cmd == CMD_DEQ) && !is_nonempty;
    rsp_d.overflow     = (req_i.cmd == CMD_ENQ) && is_full;
    if (ctl.deq) begin
      rsp_d.out_value    = entries[0].value;
      rsp_d.out_priority = entries[0].prio;
    end

    if (ctl.enq) begin
      rsp_d.head_value = flags[0] ? req_i.item_value : entries[0].value;
    end else if (ctl.deq) begin
      rsp_d.head_value = (count_q > CW'(1)) ? entries[1].value : 32'd0;
    end else if (is_nonempty) begin
      rsp_d.head_value = entries[0].value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- rtl/spq_checker.sv -----
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg for the word types and command codes.
module spq_checker import spq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input spq_in_t  req_i,
  input logic     done_o,
  input spq_out_t rsp_o
);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted command word gave no result word");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result word without a command word");

  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.underflow) |->
      (rsp_o.is_empty && rsp_o.comparisons == 5'd0 && !rsp_o.overflow))
    else $error("underflow word is inconsistent");

  a_enq_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.cmd == CMD_ENQ)) |->
      (!rsp_o.is_empty && !rsp_o.underflow))
    else $error("queue empty after an enqueue");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.overflow) |->
      (rsp_o.comparisons == 5'd0 && !rsp_o.is_empty))
    else $error("overflow word is inconsistent");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
